/* hw/rtl/stmg_pkg.sv */
// shared types and constants of the trapezoid step generator
// payload structs, command and register codes, divider request types; no dependencies
`default_nettype none

package stmg_pkg;

  localparam int unsigned PosBits   = 32;
  localparam int unsigned CountBits = 16;
  localparam int unsigned RampBits  = 8;
  localparam int unsigned ProdBits  = RampBits + CountBits;
  localparam int unsigned DivCntBits = $clog2(ProdBits);

  localparam logic [1:0] CmdTick = 2'd0;
  localparam logic [1:0] CmdGoto = 2'd1;
  localparam logic [1:0] CmdMove = 2'd2;
  localparam logic [1:0] CmdZero = 2'd3;

  localparam logic [1:0] RegCruise  = 2'd0;
  localparam logic [1:0] RegSlowest = 2'd1;
  localparam logic [1:0] RegRamp    = 2'd2;

  localparam logic [CountBits-1:0] CruiseReset  = 16'd2000;
  localparam logic [CountBits-1:0] SlowestReset = 16'd10000;
  localparam logic [RampBits-1:0]  RampReset    = 8'd50;

  typedef struct packed {
    logic [1:0]                command;
    logic signed [PosBits-1:0] target;
    logic                      move_dir;
    logic [CountBits-1:0]      move_count;
    logic [CountBits-1:0]      move_delay;
  } in_item_t;

  typedef struct packed {
    logic                      step_pulse;
    logic                      dir_out;
    logic signed [PosBits-1:0] position_now;
    logic                      moving;
    logic [PosBits-1:0]        steps_total;
    logic                      rejected;
  } out_item_t;

  typedef struct packed {
    logic                 start;
    logic [RampBits-1:0]  idx;
    logic [CountBits-1:0] span;
    logic [RampBits-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic                done;
    logic [ProdBits-1:0] quot;
  } div_rsp_t;

endpackage

`default_nettype wire

/* hw/rtl/stmg_div.sv */
// shared multiply then restoring divide unit: idx * span / divisor, one quotient bit a cycle
// depends on stmg_pkg
`default_nettype none

module stmg_div (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire stmg_pkg::div_req_t req_i,
  output stmg_pkg::div_rsp_t     rsp_o
);

  logic [stmg_pkg::ProdBits-1:0]   acc_q, acc_d;
  logic [stmg_pkg::RampBits-1:0]   rem_q, rem_d;
  logic [stmg_pkg::RampBits-1:0]   dvs_q, dvs_d;
  logic [stmg_pkg::DivCntBits-1:0] cnt_q, cnt_d;
  logic                            busy_q, busy_d;
  logic                            done_q, done_d;

  logic [stmg_pkg::RampBits:0] rem_sh;
  logic [stmg_pkg::RampBits:0] rem_sub;
  logic                        fits;

  always_comb begin
    rem_sh  = {rem_q, acc_q[stmg_pkg::ProdBits-1]};
    rem_sub = rem_sh - {1'b0, dvs_q};
    fits    = rem_sh >= {1'b0, dvs_q};

    acc_d  = acc_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;

    if (req_i.start) begin
      // product of an 8 bit index and a 16 bit span
      acc_d  = stmg_pkg::ProdBits'(req_i.idx) * stmg_pkg::ProdBits'(req_i.span);
      rem_d  = '0;
      dvs_d  = req_i.divisor;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      acc_d = {acc_q[stmg_pkg::ProdBits-2:0], fits};
      rem_d = fits ? rem_sub[stmg_pkg::RampBits-1:0] : rem_sh[stmg_pkg::RampBits-1:0];
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == stmg_pkg::DivCntBits'(stmg_pkg::ProdBits - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      rem_q  <= '0;
      dvs_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      acc_q  <= acc_d;
      rem_q  <= rem_d;
      dvs_q  <= dvs_d;
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = acc_q;

endmodule

`default_nettype wire

/* hw/rtl/stepper_trapezoid_move_generator_top.sv */
// top level of the trapezoid step generator: command sequencer, motion state, config registers
// depends on stmg_pkg and stmg_div
`default_nettype none

// Step and direction generator driven by one-tick beats. Each input beat (tick, goto, constant
// move, zero position) yields exactly one output beat carrying the step pulse, direction,
// position, busy flag, step total and a rejected flag. Most beats pass from acceptance through the
// command register into the output register; a tick that issues a step inside an acceleration or
// deceleration ramp also waits on the shared multiply and bit-serial divide unit
// that forms index * span / ramp length at one quotient bit per cycle. The input is ready
// only while the sequencer is idle and the output register is free or being drained.
// Configuration writes are always taken and should only be issued while no move is running.
module stepper_trapezoid_move_generator_top (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire stmg_pkg::in_item_t  in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output stmg_pkg::out_item_t      out_data_o,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [1:0]          cfg_index_i,
  input  wire logic [15:0]         cfg_data_i
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV
  } state_e;

  typedef enum logic [1:0] {
    PH_ACCEL,
    PH_CRUISE,
    PH_DECEL,
    PH_FINAL
  } phase_e;

  localparam int unsigned CB = stmg_pkg::CountBits;
  localparam int unsigned PB = stmg_pkg::PosBits;
  localparam int unsigned RB = stmg_pkg::RampBits;

  // skip phases of zero length
  function automatic phase_e live_phase(input phase_e p, input logic [CB-1:0] cl,
                                        input logic [RB-1:0] rl);
    phase_e r;
    r = p;
    if (r == PH_ACCEL && rl == '0) r = PH_CRUISE;
    if (r == PH_CRUISE && cl == '0) r = PH_DECEL;
    if (r == PH_DECEL && rl == '0) r = PH_FINAL;
    return r;
  endfunction

  state_e               state_q, state_d;
  stmg_pkg::in_item_t   item_q, item_d;
  stmg_pkg::out_item_t  out_q, out_d;
  logic                 out_valid_q, out_valid_d;

  logic [CB-1:0]        cruise_cfg_q, cruise_cfg_d;
  logic [CB-1:0]        slow_cfg_q, slow_cfg_d;
  logic [RB-1:0]        ramp_cfg_q, ramp_cfg_d;

  logic [PB-1:0]        pos_q, pos_d;
  logic [PB-1:0]        total_q, total_d;
  logic                 dir_q, dir_d;
  logic                 busy_q, busy_d;
  phase_e               phase_q, phase_d;
  logic [CB-1:0]        idx_q, idx_d;
  logic [RB-1:0]        ramp_len_q, ramp_len_d;
  logic [CB-1:0]        cruise_len_q, cruise_len_d;
  logic [CB-1:0]        wait_q, wait_d;
  logic [CB-1:0]        fixed_q, fixed_d;

  stmg_pkg::div_req_t   div_req;
  stmg_pkg::div_rsp_t   div_rsp;

  stmg_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  logic [CB-1:0] span;
  logic [PB-1:0] diff;
  logic [PB-1:0] mag;
  logic [CB-1:0] count;
  logic [CB-1:0] start_count;
  logic [RB-1:0] start_rl;
  logic [CB-1:0] half;
  logic          do_start;
  logic          do_step;
  logic [CB-1:0] step_delay;
  logic [CB:0]   idx_inc;
  logic [CB-1:0] phase_len;
  phase_e        succ;
  logic          pulse;
  logic          rej;
  logic          finish;
  logic [CB-1:0] part;

  assign in_ready_o  = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    span        = (slow_cfg_q >= fixed_q) ? slow_cfg_q - fixed_q : '0;
    part        = div_rsp.quot[CB-1:0];
    diff        = PB'(item_q.target) - pos_q;
    mag         = diff[PB-1] ? (~diff + 1'b1) : diff;
    count       = (|mag[PB-1:CB]) ? {CB{1'b1}} : mag[CB-1:0];
    half        = count >> 1;
    start_count = '0;
    start_rl    = '0;
    do_start    = 1'b0;
    do_step     = 1'b0;
    step_delay  = fixed_q;
    idx_inc     = '0;
    phase_len   = '0;
    succ        = PH_FINAL;
    pulse       = 1'b0;
    rej         = 1'b0;
    finish      = 1'b0;

    state_d      = state_q;
    item_d       = item_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q;
    cruise_cfg_d = cruise_cfg_q;
    slow_cfg_d   = slow_cfg_q;
    ramp_cfg_d   = ramp_cfg_q;
    pos_d        = pos_q;
    total_d      = total_q;
    dir_d        = dir_q;
    busy_d       = busy_q;
    phase_d      = phase_q;
    idx_d        = idx_q;
    ramp_len_d   = ramp_len_q;
    cruise_len_d = cruise_len_q;
    wait_d       = wait_q;
    fixed_d      = fixed_q;

    div_req.start   = 1'b0;
    div_req.idx     = idx_q[RB-1:0];
    div_req.span    = span;
    div_req.divisor = ramp_len_q;

    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        stmg_pkg::RegCruise:  cruise_cfg_d = cfg_data_i;
        stmg_pkg::RegSlowest: slow_cfg_d   = cfg_data_i;
        stmg_pkg::RegRamp:    ramp_cfg_d   = cfg_data_i[RB-1:0];
        default: ;
      endcase
    end

    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          item_d  = in_data_i;
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        finish = 1'b1;
        if (item_q.command != stmg_pkg::CmdTick && busy_q) begin
          rej = 1'b1;
        end else begin
          unique case (item_q.command)
            stmg_pkg::CmdGoto: begin
              if (diff != '0) begin
                dir_d       = diff[PB-1];
                start_rl    = (half < CB'(ramp_cfg_q)) ? half[RB-1:0] : ramp_cfg_q;
                start_count = count;
                fixed_d     = (cruise_cfg_q < slow_cfg_q) ? cruise_cfg_q : slow_cfg_q;
                do_start    = 1'b1;
              end
            end
            stmg_pkg::CmdMove: begin
              dir_d       = item_q.move_dir;
              start_rl    = '0;
              start_count = item_q.move_count;
              fixed_d     = item_q.move_delay;
              do_start    = 1'b1;
            end
            stmg_pkg::CmdZero: begin
              pos_d = '0;
            end
            default: begin
              if (busy_q) begin
                if (wait_q != '0) begin
                  wait_d = wait_q - 1'b1;
                  if (wait_q == CB'(1) && phase_q == PH_FINAL) busy_d = 1'b0;
                end else if (phase_q == PH_FINAL) begin
                  busy_d = 1'b0;
                end else if (phase_q == PH_CRUISE || ramp_len_q == '0) begin
                  do_step    = 1'b1;
                  step_delay = fixed_q;
                end else begin
                  // ramp delay needs the divider
                  div_req.start = 1'b1;
                  finish        = 1'b0;
                  state_d       = ST_DIV;
                end
              end
            end
          endcase
        end
        if (finish) state_d = ST_IDLE;
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          do_step    = 1'b1;
          step_delay = (phase_q == PH_ACCEL) ? slow_cfg_q - part : fixed_q + part;
          finish     = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (do_start) begin
      ramp_len_d   = start_rl;
      cruise_len_d = start_count - {{(CB-RB-1){1'b0}}, start_rl, 1'b0};
      wait_d       = '0;
      idx_d        = '0;
      phase_d      = live_phase(PH_ACCEL, cruise_len_d, start_rl);
      busy_d       = (phase_d != PH_FINAL);
    end

    if (do_step) begin
      pulse   = 1'b1;
      pos_d   = dir_q ? pos_q - 1'b1 : pos_q + 1'b1;
      total_d = total_q + 1'b1;
      wait_d  = step_delay;
      idx_inc = {1'b0, idx_q} + 1'b1;
      unique case (phase_q)
        PH_ACCEL: begin
          phase_len = CB'(ramp_len_q);
          succ      = PH_CRUISE;
        end
        PH_CRUISE: begin
          phase_len = cruise_len_q;
          succ      = PH_DECEL;
        end
        PH_DECEL: begin
          phase_len = CB'(ramp_len_q);
          succ      = PH_FINAL;
        end
        default: begin
          phase_len = '0;
          succ      = PH_FINAL;
        end
      endcase
      if (idx_inc >= {1'b0, phase_len}) begin
        phase_d = live_phase(succ, cruise_len_q, ramp_len_q);
        idx_d   = '0;
      end else begin
        idx_d = idx_inc[CB-1:0];
      end
      if (phase_d == PH_FINAL && step_delay == '0) busy_d = 1'b0;
    end

    if (finish) begin
      out_valid_d        = 1'b1;
      out_d.step_pulse   = pulse;
      out_d.dir_out      = dir_d;
      out_d.position_now = pos_d;
      out_d.moving       = busy_d;
      out_d.steps_total  = total_d;
      out_d.rejected     = rej;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      item_q       <= '0;
      out_q        <= '0;
      out_valid_q  <= 1'b0;
      cruise_cfg_q <= stmg_pkg::CruiseReset;
      slow_cfg_q   <= stmg_pkg::SlowestReset;
      ramp_cfg_q   <= stmg_pkg::RampReset;
      pos_q        <= '0;
      total_q      <= '0;
      dir_q        <= 1'b0;
      busy_q       <= 1'b0;
      phase_q      <= PH_ACCEL;
      idx_q        <= '0;
      ramp_len_q   <= '0;
      cruise_len_q <= '0;
      wait_q       <= '0;
      fixed_q      <= '0;
    end else begin
      state_q      <= state_d;
      item_q       <= item_d;
      out_q        <= out_d;
      out_valid_q  <= out_valid_d;
      cruise_cfg_q <= cruise_cfg_d;
      slow_cfg_q   <= slow_cfg_d;
      ramp_cfg_q   <= ramp_cfg_d;
      pos_q        <= pos_d;
      total_q      <= total_d;
      dir_q        <= dir_d;
      busy_q       <= busy_d;
      phase_q      <= phase_d;
      idx_q        <= idx_d;
      ramp_len_q   <= ramp_len_d;
      cruise_len_q <= cruise_len_d;
      wait_q       <= wait_d;
      fixed_q      <= fixed_d;
    end
  end

endmodule

`default_nettype wire

/* test/stmg_motion_monitor.sv */
// watches the command, result and register channels of the trapezoid step generator
// tracks the motion state per accepted command beat and checks each result beat in order
// depends on stmg_pkg
module stmg_motion_monitor
  import stmg_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  in_item_t            in_data_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  out_item_t           out_data_i,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic [1:0]          cfg_index_i,
  input  logic [15:0]         cfg_data_i,
  output int                  errors_o,
  output int                  pending_o,
  output logic                busy_o,
  output logic [15:0]         wait_o,
  output logic signed [31:0]  pos_o
);

  localparam logic [1:0] SegAccel  = 2'd0;
  localparam logic [1:0] SegCruise = 2'd1;
  localparam logic [1:0] SegDecel  = 2'd2;
  localparam logic [1:0] SegTail   = 2'd3;

  // register copies
  logic [15:0] cfg_cruise, cfg_slow;
  logic [7:0]  cfg_ramp;

  // motion state
  logic [31:0] pos_q, total_q;
  logic        dir_q, busy_q;
  logic [1:0]  seg_q;
  int unsigned seg_idx;
  logic [7:0]  ramp_len_q;
  int unsigned cruise_len_q;
  logic [15:0] wait_q, fixed_q;

  out_item_t predicted_outs[$];
  out_item_t want, got_next;
  int        mismatches;

  function automatic int unsigned seg_length(int unsigned s);
    if (s == SegAccel || s == SegDecel) return ramp_len_q;
    if (s == SegCruise) return cruise_len_q;
    return 0;
  endfunction

  task automatic enter_segment(input int unsigned s);
    while (s < SegTail && seg_length(s) == 0) s++;
    seg_q   = 2'(s);
    seg_idx = 0;
  endtask

  // ramp delays interpolate between the live slowest delay and the latched cruise delay
  function automatic logic [15:0] step_delay();
    int unsigned slow, span, part;
    slow = cfg_slow;
    span = (slow >= fixed_q) ? slow - fixed_q : 0;
    if (seg_q == SegCruise || ramp_len_q == 0) return fixed_q;
    part = (seg_idx * span) / ramp_len_q;
    if (seg_q == SegAccel) return 16'(slow - part);
    return 16'(fixed_q + part);
  endfunction

  task automatic arm_move(input int unsigned count);
    cruise_len_q = count - 2 * ramp_len_q;
    wait_q = '0;
    enter_segment(SegAccel);
    busy_q = (seg_q != SegTail);
  endtask

  task automatic reset_motion();
    cfg_cruise   = CruiseReset;
    cfg_slow     = SlowestReset;
    cfg_ramp     = RampReset;
    pos_q        = '0;
    total_q      = '0;
    dir_q        = 1'b0;
    busy_q       = 1'b0;
    seg_q        = SegAccel;
    seg_idx      = 0;
    ramp_len_q   = '0;
    cruise_len_q = 0;
    wait_q       = '0;
    fixed_q      = '0;
  endtask

  task automatic advance_motion(input in_item_t it, output out_item_t res);
    logic [31:0] diff, mag;
    int unsigned count;
    logic        pulse, rej;
    pulse = 1'b0;
    rej   = 1'b0;
    if (it.command != CmdTick && busy_q) begin
      rej = 1'b1;
    end else begin
      case (it.command)
        CmdGoto: begin
          diff = it.target - pos_q;
          if (diff != 0) begin
            mag   = diff[31] ? 32'd0 - diff : diff;
            count = (mag > 32'd65535) ? 65535 : mag;
            dir_q = diff[31];
            ramp_len_q = cfg_ramp;
            if ((count / 2) < ramp_len_q) ramp_len_q = 8'(count / 2);
            fixed_q = (cfg_cruise < cfg_slow) ? cfg_cruise : cfg_slow;
            arm_move(count);
          end
        end
        CmdMove: begin
          dir_q      = it.move_dir;
          ramp_len_q = '0;
          fixed_q    = it.move_delay;
          arm_move(it.move_count);
        end
        CmdZero: pos_q = '0;
        default: begin
          if (busy_q) begin
            if (wait_q > 0) begin
              wait_q--;
              if (wait_q == 0 && seg_q == SegTail) busy_q = 1'b0;
            end else if (seg_q == SegTail) begin
              busy_q = 1'b0;
            end else begin
              pulse   = 1'b1;
              pos_q   = dir_q ? pos_q - 1 : pos_q + 1;
              total_q = total_q + 1;
              wait_q  = step_delay();
              seg_idx++;
              if (seg_idx >= seg_length(seg_q)) enter_segment(32'(seg_q) + 1);
              if (seg_q == SegTail && wait_q == 0) busy_q = 1'b0;
            end
          end
        end
      endcase
    end
    res.step_pulse   = pulse;
    res.dir_out      = dir_q;
    res.position_now = pos_q;
    res.moving       = busy_q;
    res.steps_total  = total_q;
    res.rejected     = rej;
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      reset_motion();
      predicted_outs.delete();
      mismatches = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          RegCruise:  cfg_cruise = cfg_data_i;
          RegSlowest: cfg_slow   = cfg_data_i;
          RegRamp:    cfg_ramp   = cfg_data_i[7:0];
          default: ;
        endcase
      end
      // the older result leaves before a new command beat is predicted
      if (out_valid_i && out_ready_i) begin
        if (predicted_outs.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected result beat: pos %0d total %0d",
                     out_data_i.position_now, out_data_i.steps_total);
          mismatches++;
        end else begin
          want = predicted_outs.pop_front();
          if (out_data_i !== want) begin
            if (mismatches < 10)
              $display({"result mismatch: got pulse %0b dir %0b pos %0d moving %0b ",
                        "total %0d rej %0b; want pulse %0b dir %0b pos %0d moving %0b ",
                        "total %0d rej %0b"},
                       out_data_i.step_pulse, out_data_i.dir_out, out_data_i.position_now,
                       out_data_i.moving, out_data_i.steps_total, out_data_i.rejected,
                       want.step_pulse, want.dir_out, want.position_now,
                       want.moving, want.steps_total, want.rejected);
            mismatches++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        advance_motion(in_data_i, got_next);
        predicted_outs.push_back(got_next);
      end
    end
    errors_o  <= mismatches;
    pending_o <= predicted_outs.size();
    busy_o    <= busy_q;
    wait_o    <= wait_q;
    pos_o     <= pos_q;
  end

endmodule

/* test/testbench.sv */
// top of the trapezoid step generator test: clock, reset, command and register stimulus
// depends on stmg_pkg, stepper_trapezoid_move_generator_top and stmg_motion_monitor
module testbench;
  import stmg_pkg::*;

  localparam logic [1:0] RegUnused = 2'd3;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             in_valid, in_ready;
  in_item_t         in_beat;
  logic             out_valid, out_ready;
  out_item_t        out_beat;
  logic             cfg_valid, cfg_ready;
  logic [1:0]       cfg_index;
  logic [15:0]      cfg_data;

  int               mon_errors, mon_pending;
  logic             mon_busy;
  logic [15:0]      mon_wait;
  logic signed [31:0] mon_pos;

  int               gap_pct = 0;
  int               stall_pct = 0;
  bit               hold_go;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  stepper_trapezoid_move_generator_top dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_beat),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_beat),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  stmg_motion_monitor u_monitor (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_data_i   (in_beat),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_data_i  (out_beat),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .errors_o    (mon_errors),
    .pending_o   (mon_pending),
    .busy_o      (mon_busy),
    .wait_o      (mon_wait),
    .pos_o       (mon_pos)
  );

  // result side: random stalls plus one long hold-off
  initial begin
    int hold_left;
    bit hold_taken;
    hold_left  = 0;
    hold_taken = 1'b0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_go && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  initial begin
    #3000000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic in_item_t make_beat(logic [1:0] cmd, logic [31:0] tgt, logic dir,
                                         logic [15:0] cnt, logic [15:0] dly);
    in_item_t b;
    b.command    = cmd;
    b.target     = tgt;
    b.move_dir   = dir;
    b.move_count = cnt;
    b.move_delay = dly;
    return b;
  endfunction

  function automatic in_item_t tick_beat();
    return make_beat(CmdTick, $urandom, 1'($urandom_range(1)), 16'($urandom), 16'($urandom));
  endfunction

  function automatic in_item_t goto_beat(logic [31:0] tgt);
    return make_beat(CmdGoto, tgt, 1'($urandom_range(1)), 16'($urandom), 16'($urandom));
  endfunction

  function automatic in_item_t move_beat(logic dir, logic [15:0] cnt, logic [15:0] dly);
    return make_beat(CmdMove, $urandom, dir, cnt, dly);
  endfunction

  // valid stays up across back-to-back beats, so only one assignment lands per edge
  task automatic push_beat(input in_item_t b);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_beat  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (mon_pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_out();
    drain();
    while (mon_busy) begin
      repeat (16) push_beat(tick_beat());
      drain();
    end
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_all(input logic [15:0] cruise, input logic [15:0] slow,
                           input logic [7:0] ramp);
    write_reg(RegCruise, cruise);
    write_reg(RegSlowest, slow);
    write_reg(RegRamp, {8'd0, ramp});
  endtask

  initial begin
    in_item_t    b;
    logic [1:0]  last_cmd;
    bit          armed, safe;
    int          n, r, off;
    logic [15:0] c_val, s_val;
    logic [7:0]  r_val;

    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_beat   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= RegCruise;
    cfg_data  <= '0;
    hold_go   <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: idle tick, zeroing, goto to where we are, empty move
    push_beat(tick_beat());
    push_beat(make_beat(CmdZero, $urandom, 1'b1, 16'hffff, 16'hffff));
    push_beat(goto_beat(32'd0));
    push_beat(move_beat(1'b1, 16'd0, 16'hffff));
    // one step at reset settings, commands while busy are turned away
    push_beat(goto_beat(32'd1));
    push_beat(goto_beat(32'h7fff_ffff));
    push_beat(move_beat(1'b1, 16'hffff, 16'hffff));
    push_beat(make_beat(CmdZero, 32'hffff_ffff, 1'b0, 16'h0000, 16'h0000));
    run_out();
    // cruise above slowest gets clamped
    write_all(16'hffff, 16'd3, 8'd255);
    push_beat(goto_beat(mon_pos + 3));
    run_out();
    // full ramp up and down with a nonzero span
    write_all(16'd1, 16'd7, 8'd255);
    push_beat(goto_beat(mon_pos - 17));
    run_out();
    // zero delay move
    push_beat(move_beat(1'b0, 16'd6, 16'd0));
    run_out();
    // slowest dropped below the latched cruise delay mid-move
    write_all(16'd4, 16'd9, 8'd3);
    push_beat(goto_beat(mon_pos + 10));
    repeat (12) push_beat(tick_beat());
    drain();
    write_reg(RegSlowest, 16'd2);
    run_out();
    // single step where slowest is at its top
    write_all(16'd1, 16'hffff, 8'd1);
    push_beat(goto_beat(mon_pos + 1));
    run_out();
    write_reg(RegSlowest, 16'd1);
    push_beat(goto_beat(mon_pos - 2));
    run_out();
    write_reg(RegUnused, 16'ha5c3);

    // random: well-formed moves with ticks, plus turned-away and harmless noise
    last_cmd = CmdTick;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 81; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 81; end
        default: begin gap_pct = 9; stall_pct = 9; end
      endcase
      for (int s = 0; s < 3; s++) begin
        run_out();
        case ($urandom_range(5))
          0:       c_val = 16'd1;
          1:       c_val = 16'hffff;
          default: c_val = 16'($urandom_range(1, 8));
        endcase
        s_val = ($urandom_range(4) == 0) ? 16'd1 : 16'($urandom_range(2, 10));
        case ($urandom_range(5))
          0:       r_val = 8'd1;
          1:       r_val = 8'd255;
          default: r_val = 8'($urandom_range(1, 12));
        endcase
        write_all(c_val, s_val, r_val);
        if (ph == 0 && s == 1) hold_go <= 1'b1;
        armed = 1'b0;
        for (n = 0; n < 138; n++) begin
          if (!mon_busy && !armed) begin
            r = $urandom_range(99);
            if (r < 55) begin
              off = $urandom_range(1, 24);
              if ($urandom_range(1)) off = -off;
              b = goto_beat(mon_pos + off);
            end else if (r < 80) begin
              b = move_beat(1'($urandom_range(1)), 16'($urandom_range(0, 20)),
                            16'(($urandom_range(3) != 0) ? $urandom_range(0, 4)
                                                         : $urandom_range(0, 12)));
            end else if (r < 85) begin
              b = goto_beat(mon_pos);
            end else if (r < 90) begin
              b = make_beat(CmdZero, $urandom, 1'($urandom_range(1)), 16'($urandom),
                            16'($urandom));
            end else begin
              b = tick_beat();
            end
            armed = (b.command == CmdGoto || b.command == CmdMove);
          end else begin
            armed = 1'b0;
            // the monitor lags by the beat just taken; a tick can only end a move
            // when the wait is nearly over
            safe = mon_busy && (last_cmd != CmdTick || mon_wait >= 2);
            if ($urandom_range(99) < 88) begin
              b = tick_beat();
            end else if (safe) begin
              b = make_beat(2'($urandom_range(CmdGoto, CmdZero)), $urandom,
                            1'($urandom_range(1)), 16'($urandom), 16'($urandom));
            end else if ($urandom_range(1)) begin
              b = make_beat(CmdZero, $urandom, 1'($urandom_range(1)), 16'($urandom),
                            16'($urandom));
            end else begin
              b = move_beat(1'($urandom_range(1)), 16'd0, 16'($urandom));
            end
          end
          push_beat(b);
          last_cmd = b.command;
        end
      end
    end

    // saturating goto, left running at the end
    run_out();
    gap_pct   = 0;
    stall_pct = 0;
    push_beat(goto_beat(32'h8000_0000));
    repeat (30) push_beat(tick_beat());
    push_beat(make_beat(CmdMove, $urandom, 1'b1, 16'hffff, 16'hffff));
    drain();
    repeat (50) @(posedge clk);
    if (mon_errors == 0 && mon_pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
